@@ rtl/ffrx_pkg.sv @@
// ----------------------------------------------------------------------------
// ffrx_pkg
// Shared constants, codes and types of the fixed-frame receiver with the
// CRC-16/Modbus check.
// ----------------------------------------------------------------------------
package ffrx_pkg;

   localparam int PAYLOAD_BYTES = 48;
   localparam int HEADER_BYTES  = 9;
   localparam int FRAME_BYTES   = HEADER_BYTES + PAYLOAD_BYTES + 2;
   localparam int FPOS_W        = $clog2(FRAME_BYTES);
   localparam int PAY_ADDR_W    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam int POS_FIELD_W   = 6;

   // frame positions of interest
   localparam logic [FPOS_W-1:0] FPOS_HDR_END = FPOS_W'(HEADER_BYTES);
   localparam logic [FPOS_W-1:0] FPOS_CRC_LO  = FPOS_W'(HEADER_BYTES + PAYLOAD_BYTES);
   localparam logic [FPOS_W-1:0] FPOS_LAST    = FPOS_W'(FRAME_BYTES - 1);
   localparam logic [PAY_ADDR_W-1:0] PAY_LAST_IDX = PAY_ADDR_W'(PAYLOAD_BYTES - 1);

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam int          CRC_BITS  = 8;
   localparam int          CRC_CNT_W = 4;

   localparam logic [15:0] TIMER_MAX     = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [7:0]  VERSION_RESET = 8'd1;

   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [1:0] {
      STATUS_GOOD        = 2'd0,
      STATUS_CRC_ERR     = 2'd1,
      STATUS_VERSION_ERR = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_TIMEOUT = 1'b0,
      CSR_VERSION = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      status_type             status;
      logic [7:0]             packet_type;
      logic [15:0]            source_node;
      logic [15:0]            destination_node;
      logic [15:0]            sequence_id;
      logic [7:0]             payload_length;
      logic [7:0]             payload_data;
      logic [POS_FIELD_W-1:0] payload_position;
      logic                   last;
   } rsp_payload_type;

   typedef struct packed {
      logic       start;
      logic       restart;
      logic [7:0] data;
   } crc_ctl_type;

endpackage

@@ rtl/ffrx_ram.sv @@
// ----------------------------------------------------------------------------
// ffrx_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ffrx_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 48,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ffrx_crc_unit.sv @@
// ----------------------------------------------------------------------------
// ffrx_crc_unit
// Bit-serial CRC-16/Modbus engine: one byte is folded in, then shifted out
// one bit per cycle.
// ----------------------------------------------------------------------------
module ffrx_crc_unit
   import ffrx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type ctl,
   output logic [15:0] crc,
   output logic        busy
);

   logic [15:0]          crc_ff, crc_in;
   logic [CRC_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      crc_in = crc_ff;
      cnt_in = cnt_ff;
      if (cnt_ff != '0) begin
         crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
         cnt_in = cnt_ff - 1'b1;
      end else if (ctl.start) begin
         crc_in = (ctl.restart ? CRC_INIT : crc_ff) ^ {8'h00, ctl.data};
         cnt_in = CRC_CNT_W'(CRC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
         cnt_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign crc  = crc_ff;
   assign busy = (cnt_ff != '0);

endmodule

@@ rtl/fixed_frame_receiver_crc16_top.sv @@
// ----------------------------------------------------------------------------
// fixed_frame_receiver_crc16_top
// Fixed-length frame receiver: assembles 59-byte frames from a byte stream,
// checks CRC-16/Modbus and version, and streams out the payload bytes.
// ----------------------------------------------------------------------------
// A tick request or the low CRC byte leaves req_stall low. A header or payload
// byte is accepted and then holds req_stall high while the shared bit-serial
// CRC unit shifts the byte through. The high CRC byte moves the receiver to
// the check state; a bad frame then gives its single error result, a good
// frame gives 48 results, each through a payload memory read and then the
// output register, and rsp_stall can hold each result (and the check state).
// New requests are taken again once the last result sits in the output
// register.
module fixed_frame_receiver_crc16_top
   import ffrx_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  csr_index_type   csr_index,
   input  logic [15:0]     csr_wdata
);

   state_type             state_ff, state_in;
   logic [FPOS_W-1:0]     pos_ff, pos_in;
   logic [15:0]           timer_ff, timer_in;
   logic [63:0]           header_ff, header_in;
   logic [7:0]            version_ff, version_in;
   logic [15:0]           rxcrc_ff, rxcrc_in;
   logic [15:0]           timeout_ff, timeout_in;
   logic [7:0]            expver_ff, expver_in;
   logic [PAY_ADDR_W-1:0] idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;

   crc_ctl_type           crc_ctl;
   logic [15:0]           crc_value;
   logic                  crc_busy;

   logic                  ram_we;
   logic                  ram_re;
   logic [PAY_ADDR_W-1:0] ram_waddr;
   logic [7:0]            ram_rdata;

   logic                  req_fire;
   logic                  slot_free;
   logic                  timed_out;
   logic [FPOS_W-1:0]     pos_eff;
   logic [FPOS_W-1:0]     pos_m1;
   logic [FPOS_W-1:0]     pay_off;
   logic [2:0]            hdr_off;
   rsp_payload_type       rsp_hdr;

   ffrx_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .crc   (crc_value),
      .busy  (crc_busy)
   );

   ffrx_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_BYTES)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_payload.rx_byte),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE) || crc_busy;
   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // a stale partial frame restarts with the incoming byte
   assign timed_out = (pos_ff != '0) && (timer_ff > timeout_ff);
   assign pos_eff   = timed_out ? '0 : pos_ff;
   assign pos_m1    = pos_eff - FPOS_W'(1);
   assign hdr_off   = pos_m1[2:0];
   assign pay_off   = pos_eff - FPOS_HDR_END;
   assign ram_waddr = pay_off[PAY_ADDR_W-1:0];

   always_comb begin
      rsp_hdr                  = '0;
      rsp_hdr.status           = STATUS_GOOD;
      rsp_hdr.packet_type      = header_ff[7:0];
      rsp_hdr.source_node      = header_ff[23:8];
      rsp_hdr.destination_node = header_ff[39:24];
      rsp_hdr.sequence_id      = header_ff[55:40];
      rsp_hdr.payload_length   = header_ff[63:56];
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      timer_in     = timer_ff;
      header_in    = header_ff;
      version_in   = version_ff;
      rxcrc_in     = rxcrc_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      crc_ctl      = '{start: 1'b0, restart: 1'b0, data: req_payload.rx_byte};
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_payload.kind == KIND_TICK) begin
                  if ((pos_ff != '0) && (timer_ff != TIMER_MAX)) begin
                     timer_in = timer_ff + 16'd1;
                  end
               end else begin
                  if (pos_eff == '0) begin
                     timer_in  = '0;
                     header_in = '0;
                  end
                  if (pos_eff < FPOS_CRC_LO) begin
                     crc_ctl.start   = 1'b1;
                     crc_ctl.restart = (pos_eff == '0);
                     if (pos_eff == '0) begin
                        version_in = req_payload.rx_byte;
                     end else if (pos_eff < FPOS_HDR_END) begin
                        header_in[{hdr_off, 3'b000} +: 8] = req_payload.rx_byte;
                     end else begin
                        ram_we = 1'b1;
                     end
                     pos_in = pos_eff + FPOS_W'(1);
                  end else if (pos_eff == FPOS_CRC_LO) begin
                     rxcrc_in = {8'h00, req_payload.rx_byte};
                     pos_in   = pos_eff + FPOS_W'(1);
                  end else begin
                     rxcrc_in = {req_payload.rx_byte, rxcrc_ff[7:0]};
                     pos_in   = '0;
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (slot_free) begin
               if (rxcrc_ff != crc_value) begin
                  rsp_in        = rsp_hdr;
                  rsp_in.status = STATUS_CRC_ERR;
                  rsp_in.last   = 1'b1;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end else if (version_ff != expver_ff) begin
                  rsp_in        = rsp_hdr;
                  rsp_in.status = STATUS_VERSION_ERR;
                  rsp_in.last   = 1'b1;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            // read data holds until the next read, so waiting here is safe
            if (slot_free) begin
               rsp_in                  = rsp_hdr;
               rsp_in.payload_data     = ram_rdata;
               rsp_in.payload_position = POS_FIELD_W'(idx_ff);
               rsp_in.last             = (idx_ff == PAY_LAST_IDX);
               rsp_valid_in            = 1'b1;
               if (idx_ff == PAY_LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      timeout_in = timeout_ff;
      expver_in  = expver_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_in = csr_wdata;
            CSR_VERSION: expver_in  = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         timer_ff     <= '0;
         header_ff    <= '0;
         version_ff   <= '0;
         rxcrc_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         expver_ff    <= VERSION_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         timer_ff     <= timer_in;
         header_ff    <= header_in;
         version_ff   <= version_in;
         rxcrc_ff     <= rxcrc_in;
         timeout_ff   <= timeout_in;
         expver_ff    <= expver_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // error results come alone
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STATUS_GOOD)
         |-> rsp_payload.last && (rsp_payload.payload_position == '0))
      else $error("error result is not a lone last result");

   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= FPOS_LAST)
      else $error("frame position past the end of the frame");

   // no byte may be taken while the crc unit is still shifting
   assert property (@(posedge clock) disable iff (reset)
      crc_busy |-> req_stall)
      else $error("request accepted while crc unit busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last && (rsp_payload.status == STATUS_GOOD)
         |-> (rsp_payload.payload_position == POS_FIELD_W'(PAYLOAD_BYTES - 1)))
      else $error("good burst ended at the wrong payload position");

endmodule

@@ test/fixed_frame_receiver_crc16_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_frame_receiver_crc16_top_tb
// Self-checking bench for the fixed-frame receiver. Frames are built with a
// correct or corrupted CRC and sent byte by byte with timer ticks mixed in.
// A scoreboard tracks frame position, CRC, timer and stored bytes and checks
// every payload or error result against it. Covers timeouts, the zero
// timeout and register changes in the middle of a frame.
// ----------------------------------------------------------------------------
module fixed_frame_receiver_crc16_top_tb;
   import ffrx_pkg::*;

   localparam int   IDLE_PCT      = 7;
   localparam int   SETTLE_CYCLES = 24;
   localparam int   QUIET_LIMIT   = 2000;
   localparam logic KIND_BYTE     = ~KIND_TICK;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   class deframer_scoreboard;
      logic [15:0]     timeout_ticks;
      logic [7:0]      expected_version;
      int              frame_pos;
      logic [15:0]     running_crc;
      logic [15:0]     frame_timer;
      logic [15:0]     received_crc;
      logic [63:0]     header_bytes;
      logic [7:0]      version_byte;
      logic [7:0]      payload_bytes [PAYLOAD_BYTES];
      rsp_payload_type expected_rsp [$];
      int              failures;
      int              checked;
      int              good_frames;
      int              crc_errors;
      int              version_errors;

      function new();
         timeout_ticks    = TIMEOUT_RESET;
         expected_version = VERSION_RESET;
         frame_pos        = 0;
         running_crc      = CRC_INIT;
         frame_timer      = '0;
         received_crc     = '0;
         header_bytes     = '0;
         version_byte     = '0;
         failures         = 0;
         checked          = 0;
         good_frames      = 0;
         crc_errors       = 0;
         version_errors   = 0;
      endfunction

      function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
         c = c ^ {8'h00, b};
         for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         return c;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] val);
         case (idx)
            CSR_TIMEOUT: timeout_ticks = val;
            CSR_VERSION: expected_version = val[7:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type o;
         if (r.kind == KIND_TICK) begin
            if (frame_pos != 0 && frame_timer != TIMER_MAX)
               frame_timer = frame_timer + 16'd1;
            return;
         end
         // stale partial frame: this byte starts a new one
         if (frame_pos != 0 && frame_timer > timeout_ticks)
            frame_pos = 0;
         if (frame_pos == 0) begin
            frame_timer  = '0;
            running_crc  = CRC_INIT;
            header_bytes = '0;
         end
         if (frame_pos < HEADER_BYTES + PAYLOAD_BYTES) begin
            running_crc = crc_byte(running_crc, r.rx_byte);
            if (frame_pos == 0)
               version_byte = r.rx_byte;
            else if (frame_pos < HEADER_BYTES)
               header_bytes[8*(frame_pos-1) +: 8] = r.rx_byte;
            else
               payload_bytes[frame_pos-HEADER_BYTES] = r.rx_byte;
            frame_pos++;
         end else if (frame_pos == HEADER_BYTES + PAYLOAD_BYTES) begin
            received_crc = {8'h00, r.rx_byte};
            frame_pos++;
         end else begin
            received_crc[15:8] = r.rx_byte;
            frame_pos = 0;
            o.packet_type      = header_bytes[7:0];
            o.source_node      = header_bytes[23:8];
            o.destination_node = header_bytes[39:24];
            o.sequence_id      = header_bytes[55:40];
            o.payload_length   = header_bytes[63:56];
            o.payload_data     = '0;
            o.payload_position = '0;
            o.last             = 1'b1;
            if (received_crc != running_crc) begin
               o.status = STATUS_CRC_ERR;
               expected_rsp.push_back(o);
               crc_errors++;
            end else if (version_byte != expected_version) begin
               o.status = STATUS_VERSION_ERR;
               expected_rsp.push_back(o);
               version_errors++;
            end else begin
               o.status = STATUS_GOOD;
               for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                  o.payload_data     = payload_bytes[i];
                  o.payload_position = POS_FIELD_W'(i);
                  o.last             = (i == PAYLOAD_BYTES - 1);
                  expected_rsp.push_back(o);
               end
               good_frames++;
            end
         end
      endfunction

      task report(string what);
         failures++;
         if (failures <= 50)
            $display("%0t mismatch: %s", $time, what);
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_rsp.size() == 0) begin
            report($sformatf("result %h with nothing expected", got));
            return;
         end
         want = expected_rsp.pop_front();
         checked++;
         check_field("status", 16'(got.status), 16'(want.status));
         check_field("packet_type", 16'(got.packet_type), 16'(want.packet_type));
         check_field("source_node", got.source_node, want.source_node);
         check_field("destination_node", got.destination_node, want.destination_node);
         check_field("sequence_id", got.sequence_id, want.sequence_id);
         check_field("payload_length", 16'(got.payload_length),
                     16'(want.payload_length));
         check_field("payload_data", 16'(got.payload_data), 16'(want.payload_data));
         check_field("payload_position", 16'(got.payload_position),
                     16'(want.payload_position));
         check_field("last", 16'(got.last), 16'(want.last));
      endtask
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   csr_index_type   csr_index;
   logic [15:0]     csr_wdata;

   deframer_scoreboard sb;
   logic [7:0]         frame_buf [FRAME_BYTES];
   bit                 calm;
   int                 item_count;
   int                 quiet_cycles;

   fixed_frame_receiver_crc16_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function bit take_break();
      return !calm && ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   always @(negedge clock) begin
      rsp_stall <= take_break();
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_payload);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("fixed_frame_receiver_crc16_top_tb NOT OK");
      $finish;
   end

   // returns right after the accepting edge, valid still high
   task send_item(input req_payload_type p);
      @(negedge clock);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_request(p);
      item_count++;
   endtask

   task send_byte(input logic [7:0] b);
      req_payload_type p;
      p.kind    = KIND_BYTE;
      p.rx_byte = b;
      send_item(p);
   endtask

   task send_tick();
      req_payload_type p;
      p.kind    = KIND_TICK;
      p.rx_byte = 8'($urandom);
      send_item(p);
   endtask

   task settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_csr(input csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      sb.set_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task reconfigure(input logic [15:0] t, input logic [7:0] v);
      settle();
      write_csr(CSR_TIMEOUT, t);
      // upper data bits are don't-care for the version register
      write_csr(CSR_VERSION, {8'($urandom), v});
   endtask

   task build_frame(input logic [7:0] ver, input fill_type fill, input bit bad_crc);
      logic [15:0] c;
      c = CRC_INIT;
      for (int i = 0; i < FRAME_BYTES - 2; i++) begin
         if (i == 0)
            frame_buf[i] = ver;
         else if (fill == FILL_ZERO)
            frame_buf[i] = 8'h00;
         else if (fill == FILL_ONES)
            frame_buf[i] = 8'hFF;
         else
            frame_buf[i] = 8'($urandom);
         c = sb.crc_byte(c, frame_buf[i]);
      end
      frame_buf[FRAME_BYTES-2] = c[7:0];
      frame_buf[FRAME_BYTES-1] = c[15:8] ^ (bad_crc ? 8'($urandom_range(1, 255)) : 8'h00);
   endtask

   // ticks only while they cannot push the pending frame past its timeout
   task send_bytes(input int from, input int upto);
      for (int i = from; i < upto; i++) begin
         if (sb.frame_pos != 0 && sb.frame_timer < sb.timeout_ticks
             && $urandom_range(0, 99) < 8)
            send_tick();
         send_byte(frame_buf[i]);
      end
   endtask

   initial begin
      sb           = new();
      calm         = 1'b0;
      item_count   = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_TIMEOUT;
      csr_wdata    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ticks with no frame pending leave the timer alone
      send_tick();
      send_tick();
      // reset register values, all-zero content
      build_frame(VERSION_RESET, FILL_ZERO, 1'b0);
      send_bytes(0, FRAME_BYTES);

      reconfigure(16'd2, 8'hFF);
      build_frame(8'hFF, FILL_RANDOM, 1'b1);
      send_bytes(0, FRAME_BYTES);
      build_frame(8'h00, FILL_RANDOM, 1'b0);
      send_bytes(0, FRAME_BYTES);

      // partial frame expires, next byte restarts the frame; no idling here
      calm = 1'b1;
      build_frame(8'hFF, FILL_ONES, 1'b0);
      send_bytes(0, 10);
      repeat (3) send_tick();
      send_bytes(0, FRAME_BYTES);
      calm = 1'b0;

      // zero timeout: a single tick makes the next byte restart, then the
      // version register changes partway through the restarted frame
      reconfigure(16'd0, 8'h33);
      build_frame(8'h44, FILL_RANDOM, 1'b0);
      send_bytes(0, 5);
      send_tick();
      send_bytes(0, 20);
      reconfigure(16'd0, 8'h44);
      send_bytes(20, FRAME_BYTES);

      settle();
      $display("sent %0d requests, checked %0d results", item_count, sb.checked);
      $display("frames: %0d good, %0d crc errors, %0d version errors",
               sb.good_frames, sb.crc_errors, sb.version_errors);
      if (sb.failures == 0 && sb.expected_rsp.size() == 0)
         $display("fixed_frame_receiver_crc16_top_tb OK");
      else
         $display("fixed_frame_receiver_crc16_top_tb NOT OK");
      $finish;
   end

endmodule
